FILE: rtl/qmtf_pkg.sv
// Package for the reorder queue: command and status codes, beat structs,
// cell control struct and default sizes. No dependencies.
package qmtf_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_W_DEF     = 32;
  localparam int FIELD_DATA_W   = 32;
  localparam int FIELD_COUNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DEQUEUE  = 2'd1,
    CMD_TO_FRONT = 2'd2,
    CMD_TO_REAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic        [1:0]              command;
    logic signed [FIELD_DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic        [1:0]               status;
    logic signed [FIELD_DATA_W-1:0]  front_value;
    logic signed [FIELD_DATA_W-1:0]  rear_value;
    logic                            is_empty;
    logic        [FIELD_COUNT_W-1:0] entry_count;
  } out_t;

  // Update strobes broadcast to every cell; each is already qualified.
  typedef struct packed {
    logic enq;
    logic deq;
    logic to_front;
    logic to_rear;
  } cell_ctl_t;

endpackage

FILE: rtl/qmtf_cell.sv
// One queue position: holds an entry, compares it with the key and takes
// data from its left or right neighbor. Depends on qmtf_pkg.
module qmtf_cell import qmtf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int CNT_W      = $clog2(DEPTH_DEF + 1),
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  found_in,
  output logic                  found_out,
  input  logic [DATA_WIDTH-1:0] rear_in,
  output logic [DATA_WIDTH-1:0] rear_out,
  output logic [DATA_WIDTH-1:0] data_out
);

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  live;
  logic                  is_tail;
  logic                  hit;

  assign live      = (count > POS);
  assign is_tail   = (count == POS_NEXT);
  assign hit       = live && (data_r == key);
  assign found_out = found_in | hit;
  assign rear_out  = is_tail ? data_r : rear_in;
  assign data_out  = data_r;

  // Only the first match from the front moves; cells up to it shift right
  // for a move to front, cells from it to the tail shift left for a move
  // to rear.
  always_comb begin
    data_nxt = data_r;
    if (ctl.enq && (count == POS)) begin
      data_nxt = key;
    end else if (ctl.deq && live) begin
      data_nxt = right_data;
    end else if (ctl.to_front && !found_in) begin
      data_nxt = left_data;
    end else if (ctl.to_rear && found_out && live) begin
      data_nxt = is_tail ? key : right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/queue_with_move_to_front_rear.sv
// Reorder queue top level. An accepted start reaches the out_strobe beat
// through the command register, then the cell row and strobe registers.
// Throughput: one command per cycle; busy stays low, since every cell
// compares and shifts in the same cycle and the row finishes each command.
// Reset clears the entry count and strobes; entries need no clearing.
// Depends on qmtf_pkg and qmtf_cell.
module queue_with_move_to_front_rear import qmtf_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                  cmd_vld_r;
  cmd_t                  cmd_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  strobe_r;
  status_t               status_r;
  status_t               status_nxt;
  cell_ctl_t             ctl;
  logic                  found;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] rear_chain [DEPTH+1];
  logic                  find_chain [DEPTH+1];

  logic [DATA_WIDTH+FIELD_DATA_W-1:0] value_ext;
  logic [DATA_WIDTH+FIELD_DATA_W-1:0] front_ext;
  logic [DATA_WIDTH+FIELD_DATA_W-1:0] rear_ext;
  logic [CNT_W+FIELD_COUNT_W-1:0]     count_ext;

  assign busy = 1'b0;

  assign value_ext = {{DATA_WIDTH{in_item.value[FIELD_DATA_W-1]}}, in_item.value};

  // Command register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd_t'(in_item.command);
      key_r <= value_ext[DATA_WIDTH-1:0];
    end
  end

  // Cell row.
  assign find_chain[0]     = 1'b0;
  assign rear_chain[DEPTH] = '0;
  assign found             = find_chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = key_r;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = key_r;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    qmtf_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .key        (key_r),
      .left_data  (left_d),
      .right_data (right_d),
      .found_in   (find_chain[i]),
      .found_out  (find_chain[i+1]),
      .rear_in    (rear_chain[i+1]),
      .rear_out   (rear_chain[i]),
      .data_out   (cell_data[i])
    );
  end

  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    unique case (cmd_r)
      CMD_ENQUEUE: begin
        if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.enq   = cmd_vld_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_DEQUEUE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.deq   = cmd_vld_r;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_TO_FRONT: begin
        if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          ctl.to_front = cmd_vld_r;
        end
      end
      CMD_TO_REAR: begin
        if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          ctl.to_rear = cmd_vld_r;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd_vld_r;
      if (cmd_vld_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_vld_r) begin
      status_r <= status_nxt;
    end
  end

  // Front and rear are read from the row in the beat cycle, after the update.
  assign front_ext = {{FIELD_DATA_W{cell_data[0][DATA_WIDTH-1]}}, cell_data[0]};
  assign rear_ext  = {{FIELD_DATA_W{rear_chain[0][DATA_WIDTH-1]}}, rear_chain[0]};
  assign count_ext = {{FIELD_COUNT_W{1'b0}}, count_r};

  assign out_strobe           = strobe_r;
  assign out_item.status      = status_r;
  assign out_item.is_empty    = (count_r == '0);
  assign out_item.entry_count = count_ext[FIELD_COUNT_W-1:0];
  assign out_item.front_value = (count_r == '0) ? '0 : front_ext[FIELD_DATA_W-1:0];
  assign out_item.rear_value  = (count_r == '0) ? '0 : rear_ext[FIELD_DATA_W-1:0];

  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_strobe)
    else $error("accepted command produced no result beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds queue depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.status == ST_FULL) |-> count_r == FULL_CNT)
    else $error("full status reported on a queue with room");

endmodule

FILE: dv/tb_top.sv
// Testbench for the reorder queue: directed and random commands with a
// built-in queue predictor and a result checker on every out_strobe beat.
// Depends on qmtf_pkg and queue_with_move_to_front_rear.
`timescale 1ns / 100ps

module tb_top;
  import qmtf_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int QUIET_LIMIT = 1000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_strobe;
  out_t out_item;

  queue_with_move_to_front_rear dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted queue contents, front at index 0.
  logic signed [31:0] cells[$];
  out_t               pending_results[$];

  int n_accepted;
  int n_checked;
  int n_errors;
  int n_full;
  int n_empty;
  int n_notfound;
  int n_moves_ok;
  int peak_count;
  int quiet_cycles;
  int idle_pct;

  logic signed [31:0] value_pool[8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
    32'sd7, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1
  };

  // Applies one command to the predicted queue and returns the result it causes.
  function automatic out_t apply_queue_command(in_t beat);
    out_t               r;
    int                 hit;
    logic signed [31:0] moved;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    for (int i = 0; i < cells.size(); i++)
      if (hit < 0 && cells[i] == beat.value) hit = i;
    case (cmd_t'(beat.command))
      CMD_ENQUEUE: begin
        if (cells.size() >= QDEPTH) r.status = ST_FULL;
        else cells.insert(cells.size(), beat.value);
      end
      CMD_DEQUEUE: begin
        if (cells.size() == 0) r.status = ST_EMPTY;
        else void'(cells.pop_front());
      end
      CMD_TO_FRONT: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          moved = cells[hit];
          cells.delete(hit);
          cells.push_front(moved);
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          moved = cells[hit];
          cells.delete(hit);
          cells.insert(cells.size(), moved);
        end
      end
    endcase
    if (cells.size() == 0) begin
      r.front_value = '0;
      r.rear_value  = '0;
      r.is_empty    = 1'b1;
    end else begin
      r.front_value = cells[0];
      r.rear_value  = cells[cells.size() - 1];
      r.is_empty    = 1'b0;
    end
    r.entry_count = FIELD_COUNT_W'(cells.size());
    return r;
  endfunction

  task automatic report_mismatch(string field, logic signed [31:0] got,
                                 logic signed [31:0] want);
    n_errors++;
    $display("%0t: result %0d, %s: got %0d, expected %0d",
             $realtime, n_checked, field, got, want);
  endtask

  task automatic check_result(out_t got, out_t want);
    if (got.status != want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.front_value != want.front_value)
      report_mismatch("front_value", got.front_value, want.front_value);
    if (got.rear_value != want.rear_value)
      report_mismatch("rear_value", got.rear_value, want.rear_value);
    if (got.is_empty != want.is_empty)
      report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    if (got.entry_count != want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
  endtask

  // Prediction happens before the check in the same process, so a result
  // can never race its own expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (start && !busy) begin
        want = apply_queue_command(in_item);
        pending_results.insert(pending_results.size(), want);
        case (status_t'(want.status))
          ST_FULL:     n_full++;
          ST_EMPTY:    n_empty++;
          ST_NOTFOUND: n_notfound++;
          default:     if (in_item.command inside {CMD_TO_FRONT, CMD_TO_REAR}) n_moves_ok++;
        endcase
        if (int'(want.entry_count) > peak_count) peak_count = int'(want.entry_count);
        n_accepted++;
        quiet_cycles = 0;
      end
      if (out_strobe) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no command", 32'sd1, 32'sd0);
        end else begin
          check_result(out_item, pending_results.pop_front());
        end
        n_checked++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $realtime, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_command(cmd_t cmd, logic signed [31:0] value);
    int target;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start           = 1'b1;
    in_item.command = cmd;
    in_item.value   = value;
    target          = n_accepted + 1;
    wait (n_accepted >= target);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    wait (pending_results.size() == 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return value_pool[$urandom_range(0, 7)];
    if (r < 90 || cells.size() == 0) return $urandom;
    return cells[$urandom_range(0, cells.size() - 1)];
  endfunction

  function automatic logic signed [31:0] pick_key();
    if (cells.size() > 0 && $urandom_range(0, 99) < 70)
      return cells[$urandom_range(0, cells.size() - 1)];
    return pick_value();
  endfunction

  // Mode 0 leans toward filling, mode 1 toward draining, mode 2 is even.
  function automatic cmd_t pick_command(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0:       return r < 55 ? CMD_ENQUEUE : r < 65 ? CMD_DEQUEUE :
                      r < 83 ? CMD_TO_FRONT : CMD_TO_REAR;
      1:       return r < 12 ? CMD_ENQUEUE : r < 62 ? CMD_DEQUEUE :
                      r < 81 ? CMD_TO_FRONT : CMD_TO_REAR;
      default: return r < 30 ? CMD_ENQUEUE : r < 55 ? CMD_DEQUEUE :
                      r < 78 ? CMD_TO_FRONT : CMD_TO_REAR;
    endcase
  endfunction

  task automatic send_random(int mode);
    cmd_t cmd;
    cmd = pick_command(mode);
    if (cmd == CMD_ENQUEUE) send_command(cmd, pick_value());
    else if (cmd == CMD_DEQUEUE) send_command(cmd, $urandom);
    else send_command(cmd, pick_key());
  endtask

  task automatic test_empty_queue();
    send_command(CMD_DEQUEUE, 32'sd0);
    send_command(CMD_TO_FRONT, 32'sd0);
    send_command(CMD_TO_REAR, -32'sd1);
  endtask

  // Fills to the brim with extremes and repeated keys, then exercises every
  // flavor of move, including moves of the entry already at the target end.
  task automatic test_fill_and_moves();
    logic signed [31:0] fill[16] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd7, 32'sh5555_5555,
      32'sd7, 32'shAAAA_AAAA, 32'sd1, -32'sd2, 32'sd100, 32'sd7, 32'sh1234,
      -32'sd100, 32'sd3, 32'sd9
    };
    foreach (fill[i]) send_command(CMD_ENQUEUE, fill[i]);
    send_command(CMD_ENQUEUE, 32'sd42);
    send_command(CMD_TO_FRONT, 32'sd7);
    send_command(CMD_TO_FRONT, 32'sd7);
    send_command(CMD_TO_REAR, 32'sh8000_0000);
    send_command(CMD_TO_REAR, 32'sh8000_0000);
    send_command(CMD_TO_FRONT, 32'sd12345);
    send_command(CMD_TO_REAR, 32'sh0F0F_0F0F);
    send_command(CMD_DEQUEUE, 32'sh7FFF_FFFF);
  endtask

  task automatic test_random_mix(int n_items);
    int mode;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) mode = $urandom_range(0, 2);
      send_random(mode);
    end
  endtask

  task automatic test_back_to_back(int n_items);
    idle_pct = 0;
    test_random_mix(n_items);
    idle_pct = 36;
  endtask

  task automatic test_pause_and_resume(int n_items);
    test_random_mix(n_items / 2);
    wait_drained();
    test_random_mix(n_items - n_items / 2);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    idle_pct   = 36;
    n_accepted = 0;
    n_checked  = 0;
    n_errors   = 0;
    n_full     = 0;
    n_empty    = 0;
    n_notfound = 0;
    n_moves_ok = 0;
    peak_count = 0;
    quiet_cycles = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_fill_and_moves();
    test_random_mix(450);
    test_back_to_back(300);
    test_pause_and_resume(300);
    test_random_mix(270);

    wait_drained();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still pending", 32'(pending_results.size()), 32'sd0);
    $display("Sent %0d commands, checked %0d results, peak occupancy %0d.",
             n_accepted, n_checked, peak_count);
    $display("Seen: %0d full, %0d empty, %0d not found, %0d successful moves.",
             n_full, n_empty, n_notfound, n_moves_ok);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
